// ===== rtl/core/ilha_pkg.sv =====
`timescale 1ns / 1ps
package ilha_pkg;

  // Heap geometry
  localparam int unsigned HeapBytesDefault = 4096;
  localparam int unsigned HdrBytes = 8;
  localparam int unsigned MinSplit = 12;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [2:0] ST_NO_FIT    = 3'd2;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Header write selections
  localparam logic [2:0] WR_NONE        = 3'd0;
  localparam logic [2:0] WR_INIT_FIRST  = 3'd1;
  localparam logic [2:0] WR_INIT_END    = 3'd2;
  localparam logic [2:0] WR_ALLOC_WHOLE = 3'd3;
  localparam logic [2:0] WR_SPLIT_REST  = 3'd4;
  localparam logic [2:0] WR_SPLIT_HEAD  = 3'd5;
  localparam logic [2:0] WR_FREE_TGT    = 3'd6;
  localparam logic [2:0] WR_MERGE       = 3'd7;

  typedef struct packed {
    logic        kind;
    logic [12:0] request_bytes;
    logic [12:0] payload_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] result_offset;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       rd_cur;
    logic       rd_nxt;
    logic       adv;
    logic       latch_nxt;
    logic       merge_prev;
    logic [2:0] wr_sel;
    logic       res_valid;
    logic [2:0] res_status;
    logic       res_off;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_zero;
    logic free_bad;
    logic cur_is_end;
    logic cur_eq_tgt;
    logic cur_gt_tgt;
    logic rd_alloc;
    logic fit;
    logic split;
    logic prev_free;
    logic nxt_is_end;
  } sts_t;

endpackage

// ===== rtl/core/implicit_list_heap_allocator.sv =====
`timescale 1ns / 1ps
// Flow: a request rejected on its fields gives its result the cycle after acceptance;
// otherwise each header visited on the chain is checked and read before the walk moves on
// or stops, then the headers are updated, with the result registered from the last step.
// Throughput: one request at a time; busy_o, if raised, falls as the result is strobed.
// Reset: busy while the first and then the terminal header are written.
// Results are strobed for one cycle by valid_o; the receiver cannot stall.
module implicit_list_heap_allocator #(
  parameter int unsigned HEAP_BYTES = ilha_pkg::HeapBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  ilha_pkg::req_t req_i,
  output logic           busy_o,
  output logic           valid_o,
  output ilha_pkg::res_t res_o
);

  ilha_pkg::cmd_t cmd;
  ilha_pkg::sts_t sts;
  logic           busy;

  assign busy_o = busy;

  // Sequencer
  ilha_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .kind_i (req_i.kind),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // Header store and walk registers
  ilha_datapath #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

endmodule

// ===== rtl/core/ilha_datapath.sv =====
`timescale 1ns / 1ps
module ilha_datapath #(
  parameter int unsigned HEAP_BYTES = ilha_pkg::HeapBytesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ilha_pkg::req_t  req_i,
  input  ilha_pkg::cmd_t  cmd_i,
  output ilha_pkg::sts_t  sts_o,
  output logic            valid_o,
  output ilha_pkg::res_t  res_o
);

  localparam int unsigned OW = $clog2(HEAP_BYTES);
  localparam int unsigned Words = HEAP_BYTES / 4;
  localparam int unsigned CW = ((OW > 13) ? OW : 13) + 2;
  localparam logic [OW-1:0] EndHdr = OW'(HEAP_BYTES - ilha_pkg::HdrBytes);

  // Header store: next offset and allocated bit per word
  logic [OW:0] mem [Words];
  logic [OW-1:0] rd_next_q;
  logic          rd_alloc_q;

  logic [OW-1:0] cur_q, prev_q, nxt_q, base_q, tgt_q;
  logic          have_prev_q, prev_alloc_q;
  logic [CW-1:0] need_q;

  logic [CW-1:0] req_w, pay_w, need_d, tgt_w, span_w, rest_w;
  logic [OW-1:0] rd_addr, wr_addr, wr_next;
  logic          wr_alloc, wr_en;

  // Input checks
  assign req_w  = CW'(req_i.request_bytes);
  assign pay_w  = CW'(req_i.payload_offset);
  assign need_d = ((req_w + CW'(3)) & ~CW'(3)) + CW'(ilha_pkg::HdrBytes);
  assign tgt_w  = pay_w - CW'(ilha_pkg::HdrBytes);

  assign sts_o.req_zero = (req_i.request_bytes == 13'd0);
  assign sts_o.free_bad = (pay_w < CW'(ilha_pkg::HdrBytes)) || (tgt_w[1:0] != 2'b00)
                          || (tgt_w > CW'(EndHdr));

  // Walk status
  assign span_w = CW'(rd_next_q) - CW'(cur_q);
  assign rest_w = CW'(cur_q) + need_q;
  assign sts_o.cur_is_end = (cur_q == EndHdr);
  assign sts_o.cur_eq_tgt = (cur_q == tgt_q);
  assign sts_o.cur_gt_tgt = (cur_q > tgt_q);
  assign sts_o.rd_alloc   = rd_alloc_q;
  assign sts_o.fit        = !rd_alloc_q && (span_w >= need_q);
  assign sts_o.split      = (span_w - need_q) >= CW'(ilha_pkg::MinSplit);
  assign sts_o.prev_free  = have_prev_q && !prev_alloc_q;
  assign sts_o.nxt_is_end = (nxt_q == EndHdr);

  // Header write selection
  always_comb begin
    wr_en    = 1'b1;
    wr_addr  = cur_q;
    wr_next  = rd_next_q;
    wr_alloc = 1'b0;
    case (cmd_i.wr_sel)
      ilha_pkg::WR_INIT_FIRST: begin
        wr_addr = '0;
        wr_next = EndHdr;
      end
      ilha_pkg::WR_INIT_END: begin
        wr_addr = EndHdr;
        wr_next = '0;
      end
      ilha_pkg::WR_ALLOC_WHOLE: wr_alloc = 1'b1;
      ilha_pkg::WR_SPLIT_REST:  wr_addr = rest_w[OW-1:0];
      ilha_pkg::WR_SPLIT_HEAD: begin
        wr_next  = rest_w[OW-1:0];
        wr_alloc = 1'b1;
      end
      ilha_pkg::WR_FREE_TGT: wr_addr = cur_q;
      ilha_pkg::WR_MERGE: begin
        wr_addr = prev_q;
        wr_next = nxt_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Merge with the following block writes the running base
  logic [OW-1:0] wr_addr_f;
  assign wr_addr_f = (cmd_i.wr_sel == ilha_pkg::WR_FREE_TGT && cmd_i.merge_prev)
                     ? base_q : wr_addr;
  assign rd_addr = cmd_i.rd_nxt ? nxt_q : cur_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr_f[OW-1:2]] <= {wr_next, wr_alloc};
    end
    if (cmd_i.rd_cur || cmd_i.rd_nxt) begin
      {rd_next_q, rd_alloc_q} <= mem[rd_addr[OW-1:2]];
    end
  end

  // Walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q  <= '0;
      need_q <= need_d;
      tgt_q  <= tgt_w[OW-1:0];
    end
    if (cmd_i.adv) begin
      prev_q       <= cur_q;
      prev_alloc_q <= rd_alloc_q;
      cur_q        <= rd_next_q;
    end
    if (cmd_i.latch_nxt) begin
      nxt_q  <= rd_next_q;
      base_q <= cur_q;
    end
    if (cmd_i.wr_sel == ilha_pkg::WR_MERGE) begin
      base_q <= prev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
    end else if (cmd_i.load) begin
      have_prev_q <= 1'b0;
    end else if (cmd_i.adv) begin
      have_prev_q <= 1'b1;
    end
  end

  // Result register
  logic [CW-1:0] off_w;
  assign off_w = CW'(cur_q) + CW'(ilha_pkg::HdrBytes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= cmd_i.res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_valid) begin
      res_o.status        <= cmd_i.res_status;
      res_o.result_offset <= cmd_i.res_off ? off_w[12:0] : 13'd0;
    end
  end

endmodule

// ===== rtl/core/ilha_ctrl.sv =====
`timescale 1ns / 1ps
module ilha_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            kind_i,
  input  ilha_pkg::sts_t  sts_i,
  output ilha_pkg::cmd_t  cmd_o,
  output logic            busy_o
);

  localparam logic [3:0] S_INIT0 = 4'd0;
  localparam logic [3:0] S_INIT1 = 4'd1;
  localparam logic [3:0] S_IDLE  = 4'd2;
  localparam logic [3:0] S_A_CHK = 4'd3;
  localparam logic [3:0] S_A_EV  = 4'd4;
  localparam logic [3:0] S_A_SPL = 4'd5;
  localparam logic [3:0] S_F_CHK = 4'd6;
  localparam logic [3:0] S_F_ADV = 4'd7;
  localparam logic [3:0] S_T_EV  = 4'd8;
  localparam logic [3:0] S_F_PRV = 4'd9;
  localparam logic [3:0] S_F_NXT = 4'd10;
  localparam logic [3:0] S_N_EV  = 4'd11;

  logic [3:0] state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.wr_sel = ilha_pkg::WR_NONE;
    case (state_q)
      S_INIT0: begin
        cmd_o.wr_sel = ilha_pkg::WR_INIT_FIRST;
        state_d = S_INIT1;
      end
      S_INIT1: begin
        cmd_o.wr_sel = ilha_pkg::WR_INIT_END;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (kind_i == ilha_pkg::KIND_ALLOC) begin
            if (sts_i.req_zero) begin
              cmd_o.res_valid  = 1'b1;
              cmd_o.res_status = ilha_pkg::ST_BAD_SIZE;
            end else begin
              state_d = S_A_CHK;
            end
          end else if (sts_i.free_bad) begin
            cmd_o.res_valid  = 1'b1;
            cmd_o.res_status = ilha_pkg::ST_BAD_ADDR;
          end else begin
            state_d = S_F_CHK;
          end
        end
      end
      S_A_CHK: begin
        if (sts_i.cur_is_end) begin
          cmd_o.res_valid  = 1'b1;
          cmd_o.res_status = ilha_pkg::ST_NO_FIT;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d = S_A_EV;
        end
      end
      S_A_EV: begin
        if (sts_i.fit && sts_i.split) begin
          cmd_o.wr_sel = ilha_pkg::WR_SPLIT_REST;
          state_d = S_A_SPL;
        end else if (sts_i.fit) begin
          cmd_o.wr_sel     = ilha_pkg::WR_ALLOC_WHOLE;
          cmd_o.res_valid  = 1'b1;
          cmd_o.res_status = ilha_pkg::ST_OK;
          cmd_o.res_off    = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d = S_A_CHK;
        end
      end
      S_A_SPL: begin
        cmd_o.wr_sel     = ilha_pkg::WR_SPLIT_HEAD;
        cmd_o.res_valid  = 1'b1;
        cmd_o.res_status = ilha_pkg::ST_OK;
        cmd_o.res_off    = 1'b1;
        state_d = S_IDLE;
      end
      S_F_CHK: begin
        if (sts_i.cur_eq_tgt && sts_i.cur_is_end) begin
          cmd_o.res_valid  = 1'b1;
          cmd_o.res_status = ilha_pkg::ST_NOT_ALLOC;
          state_d = S_IDLE;
        end else if (sts_i.cur_eq_tgt) begin
          cmd_o.rd_cur = 1'b1;
          state_d = S_T_EV;
        end else if (sts_i.cur_is_end || sts_i.cur_gt_tgt) begin
          cmd_o.res_valid  = 1'b1;
          cmd_o.res_status = ilha_pkg::ST_BAD_ADDR;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d = S_F_ADV;
        end
      end
      S_F_ADV: begin
        cmd_o.adv = 1'b1;
        state_d = S_F_CHK;
      end
      S_T_EV: begin
        if (sts_i.rd_alloc) begin
          cmd_o.latch_nxt = 1'b1;
          cmd_o.wr_sel    = ilha_pkg::WR_FREE_TGT;
          state_d = S_F_PRV;
        end else begin
          cmd_o.res_valid  = 1'b1;
          cmd_o.res_status = ilha_pkg::ST_NOT_ALLOC;
          state_d = S_IDLE;
        end
      end
      S_F_PRV: begin
        if (sts_i.prev_free) begin
          cmd_o.wr_sel = ilha_pkg::WR_MERGE;
        end
        state_d = S_F_NXT;
      end
      S_F_NXT: begin
        if (sts_i.nxt_is_end) begin
          cmd_o.res_valid  = 1'b1;
          cmd_o.res_status = ilha_pkg::ST_OK;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_nxt = 1'b1;
          state_d = S_N_EV;
        end
      end
      S_N_EV: begin
        // free successor: rewrite base header to skip it
        if (!sts_i.rd_alloc) begin
          cmd_o.wr_sel     = ilha_pkg::WR_FREE_TGT;
          cmd_o.merge_prev = 1'b1;
        end
        cmd_o.res_valid  = 1'b1;
        cmd_o.res_status = ilha_pkg::ST_OK;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT0;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/ilha_checker.sv =====
`timescale 1ns / 1ps
module ilha_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           valid_o,
  input ilha_pkg::res_t res_o
);

  // Status codes stay within the defined set
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.status == ilha_pkg::ST_OK || res_o.status == ilha_pkg::ST_BAD_SIZE
      || res_o.status == ilha_pkg::ST_NO_FIT || res_o.status == ilha_pkg::ST_BAD_ADDR
      || res_o.status == ilha_pkg::ST_NOT_ALLOC))
    else $error("bad status code");

  // Failures carry a zero offset
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.status != ilha_pkg::ST_OK) |-> (res_o.result_offset == 13'd0))
    else $error("offset on failed request");

  // An accepted request is either answered next cycle or keeps the block busy
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (valid_o || busy_o))
    else $error("request dropped");

  // A result follows an accepted request or a busy cycle
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(start_i) || $past(busy_o)))
    else $error("result without request");

endmodule

bind implicit_list_heap_allocator ilha_checker u_ilha_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .valid_o(valid_o),
  .res_o  (res_o)
);
